// ----- src/mbr_pkg.sv -----
// Shared constants, codes and types of the bus router with timer compare.
package mbr_pkg;

  localparam int RAM_BYTES  = 1048576;
  localparam int VRAM_BYTES = 307200;
  localparam int RAM_AW     = $clog2(RAM_BYTES);
  localparam int VRAM_AW    = $clog2(VRAM_BYTES);

  localparam logic [31:0] MTIME_LO_ADDR = 32'h0200_BFF8;
  localparam logic [31:0] MTIME_HI_ADDR = 32'h0200_BFFC;
  localparam logic [31:0] CMP_LO_ADDR   = 32'h0200_4000;
  localparam logic [31:0] CMP_HI_ADDR   = 32'h0200_4004;
  localparam logic [31:0] VIDEO_BASE    = 32'h0400_0000;
  localparam logic [31:0] VIDEO_END     = 32'h0404_B000;
  localparam logic [31:0] KEY_ADDR      = 32'h0300_0000;
  localparam logic [31:0] UART_ADDR     = 32'h1000_0000;
  localparam logic [63:0] CMP_RESET     = 64'hFFFF_FFFF_FFFF_FFFF;

  // Offset into the video window plus the largest byte index of one item.
  localparam int VID_OFF_W = $clog2(int'(VIDEO_END - VIDEO_BASE) + 4);
  localparam int STEP_W    = (RAM_AW > VID_OFF_W) ? RAM_AW : VID_OFF_W;

  // The clearing pass sweeps both memories at once.
  localparam int CLR_N = (RAM_BYTES > VRAM_BYTES) ? RAM_BYTES : VRAM_BYTES;
  localparam int CLR_W = $clog2(CLR_N);

  typedef enum logic [2:0] {
    OP_RD8  = 3'd0,
    OP_RD16 = 3'd1,
    OP_RD32 = 3'd2,
    OP_WR8  = 3'd3,
    OP_WR16 = 3'd4,
    OP_WR32 = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    K_IMM = 2'd0,
    K_RD  = 2'd1,
    K_WR  = 2'd2,
    K_VID = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_IDLE   = 2'd1,
    ST_ACCESS = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         last;
    logic [STEP_W-1:0]  base;
    logic [31:0]        rdata;
    logic               uart_valid;
    logic [7:0]         uart_byte;
    logic               fault;
    logic               cmp_lo_we;
    logic               cmp_hi_we;
  } dec_t;

endpackage

// ----- src/mmio_bus_router_with_timer_compare.sv -----
// Top level: bus router with byte-serial RAM sequencer and timer compare register.
// An item is accepted in IDLE, steps through ACCESS for each RAM or video byte touched (1, 2 or 4),
// then waits in FINISH until the output is free; device, fault and unmapped items skip ACCESS.
// The result is registered on leaving FINISH; one byte memory port serves a byte a cycle.
// After reset a clearing pass zeroes main and video RAM, sweeping max(RAM_BYTES, VRAM_BYTES)
// addresses (1048576), during which no item is accepted; the compare register resets to all ones.
module mmio_bus_router_with_timer_compare import mbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [63:0] timer_now_i,
  input  logic [7:0]  key_code_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] read_data_o,
  output logic        uart_valid_o,
  output logic [7:0]  uart_byte_o,
  output logic        fault_o,
  output logic [63:0] compare_value_o
);

  state_e            state_q, state_d;
  dec_t              dec, dec_q;
  logic [31:0]       wd_q;
  logic [31:0]       acc_q, acc_d;
  logic [1:0]        idx_q;
  logic [1:0]        lane_q;
  logic              pend_q;
  logic [CLR_W-1:0]  clr_q;
  logic [63:0]       cmp_q;
  logic [STEP_W-1:0] step_addr;
  logic              in_acc;
  logic              out_free;

  logic               ram_we;
  logic [RAM_AW-1:0]  ram_addr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;
  logic               vram_we;
  logic [VRAM_AW-1:0] vram_addr;
  logic [7:0]         vram_wdata;

  logic        out_valid_q;
  logic [31:0] read_data_q;
  logic        uart_valid_q;
  logic [7:0]  uart_byte_q;
  logic        fault_q;
  logic [63:0] compare_value_q;

  mbr_decode u_decode (
    .op_i         (op_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .timer_now_i  (timer_now_i),
    .key_code_i   (key_code_i),
    .cmp_i        (cmp_q),
    .dec_o        (dec)
  );

  mbr_ram #(.WIDTH(8), .DEPTH(RAM_BYTES)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Video RAM is write-only on the bus, so its read port stays open.
  mbr_ram #(.WIDTH(8), .DEPTH(VRAM_BYTES)) u_video_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .addr_i  (vram_addr),
    .wdata_i (vram_wdata),
    .rdata_o ()
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Shared address adder: byte index onto the RAM address or video offset.
  assign step_addr = dec_q.base + STEP_W'(idx_q);

  // Read data arrives in the cycle after the byte was addressed.
  assign acc_d = pend_q ? (acc_q | ({24'b0, ram_rdata} << {lane_q, 3'b000})) : acc_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_q == CLR_W'(CLR_N - 1)) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = (dec.kind == K_IMM) ? ST_FINISH : ST_ACCESS;
      ST_ACCESS: if (idx_q == dec_q.last) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_addr   = '0;
    ram_wdata  = '0;
    vram_we    = 1'b0;
    vram_addr  = '0;
    vram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = {1'b0, clr_q} < (CLR_W + 1)'(RAM_BYTES);
        ram_addr  = clr_q[RAM_AW-1:0];
        vram_we   = {1'b0, clr_q} < (CLR_W + 1)'(VRAM_BYTES);
        vram_addr = clr_q[VRAM_AW-1:0];
      end
      ST_ACCESS: begin
        ram_addr   = step_addr[RAM_AW-1:0];
        ram_we     = (dec_q.kind == K_WR);
        ram_wdata  = 8'(wd_q >> {idx_q, 3'b000});
        // Bytes past the end of video RAM are clipped.
        vram_we    = (dec_q.kind == K_VID) &&
                     ({1'b0, step_addr} < (STEP_W + 1)'(VRAM_BYTES));
        vram_addr  = step_addr[VRAM_AW-1:0];
        vram_wdata = 8'(wd_q >> {idx_q, 3'b000});
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      cmp_q       <= CMP_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + CLR_W'(1);
      if (in_acc) begin
        idx_q <= '0;
      end else if (state_q == ST_ACCESS) begin
        idx_q <= idx_q + 2'd1;
      end
      pend_q <= (state_q == ST_ACCESS) && (dec_q.kind == K_RD);
      if (in_acc && dec.cmp_lo_we) cmp_q[31:0]  <= write_data_i;
      if (in_acc && dec.cmp_hi_we) cmp_q[63:32] <= write_data_i;
      if (out_free) out_valid_q <= (state_q == ST_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    lane_q <= idx_q;
    if (in_acc) begin
      dec_q <= dec;
      wd_q  <= write_data_i;
      acc_q <= dec.rdata;
    end else begin
      acc_q <= acc_d;
    end
    if (state_q == ST_FINISH && out_free) begin
      read_data_q     <= acc_d;
      uart_valid_q    <= dec_q.uart_valid;
      uart_byte_q     <= dec_q.uart_byte;
      fault_q         <= dec_q.fault;
      compare_value_q <= cmp_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = read_data_q;
  assign uart_valid_o    = uart_valid_q;
  assign uart_byte_o     = uart_byte_q;
  assign fault_o         = fault_q;
  assign compare_value_o = compare_value_q;

endmodule

// ----- src/mbr_ram.sv -----
// Generic single-port RAM with registered read data.
module mbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

// ----- src/mbr_decode.sv -----
// Address decoder: classifies one bus access and resolves device accesses.
module mbr_decode import mbr_pkg::*; (
  input  logic [2:0]  op_i,
  input  logic [31:0] address_i,
  input  logic [31:0] write_data_i,
  input  logic [63:0] timer_now_i,
  input  logic [7:0]  key_code_i,
  input  logic [63:0] cmp_i,
  output dec_t        dec_o
);

  logic [2:0]        nbytes;
  logic [32:0]       end_addr;
  logic              fits;
  logic [31:0]       vid_off;
  logic [STEP_W-1:0] ram_base;
  logic [STEP_W-1:0] vid_base;

  always_comb begin
    unique case (op_e'(op_i))
      OP_RD8, OP_WR8:   nbytes = 3'd1;
      OP_RD16, OP_WR16: nbytes = 3'd2;
      default:          nbytes = 3'd4;
    endcase
  end

  // The sum is one bit wider so that accesses near the top never wrap.
  assign end_addr = {1'b0, address_i} + {30'b0, nbytes};
  assign fits     = end_addr <= 33'(RAM_BYTES);
  assign vid_off  = address_i - VIDEO_BASE;
  assign ram_base = STEP_W'(address_i[RAM_AW-1:0]);
  assign vid_base = STEP_W'(vid_off[VID_OFF_W-1:0]);

  always_comb begin
    dec_o      = '0;
    dec_o.kind = K_IMM;
    dec_o.last = 2'(nbytes - 3'd1);
    dec_o.base = ram_base;
    unique case (op_e'(op_i))
      OP_RD8, OP_RD16: begin
        priority if (address_i == KEY_ADDR) dec_o.rdata = {24'b0, key_code_i};
        else if (fits)                      dec_o.kind  = K_RD;
        else                                dec_o.fault = 1'b1;
      end
      OP_RD32: begin
        priority if (address_i == MTIME_LO_ADDR) dec_o.rdata = timer_now_i[31:0];
        else if (address_i == MTIME_HI_ADDR)     dec_o.rdata = timer_now_i[63:32];
        else if (address_i == CMP_LO_ADDR)       dec_o.rdata = cmp_i[31:0];
        else if (address_i == CMP_HI_ADDR)       dec_o.rdata = cmp_i[63:32];
        else if (fits)                           dec_o.kind  = K_RD;
      end
      OP_WR8: begin
        priority if (address_i == UART_ADDR) begin
          dec_o.uart_valid = 1'b1;
          dec_o.uart_byte  = write_data_i[7:0];
        end else if (fits) begin
          dec_o.kind = K_WR;
        end else begin
          dec_o.fault = 1'b1;
        end
      end
      OP_WR16: begin
        if (fits) dec_o.kind  = K_WR;
        else      dec_o.fault = 1'b1;
      end
      OP_WR32: begin
        priority if (address_i == CMP_LO_ADDR) begin
          dec_o.cmp_lo_we = 1'b1;
        end else if (address_i == CMP_HI_ADDR) begin
          dec_o.cmp_hi_we = 1'b1;
        end else if (address_i >= VIDEO_BASE && address_i < VIDEO_END) begin
          dec_o.kind = K_VID;
          dec_o.base = vid_base;
        end else if (fits) begin
          dec_o.kind = K_WR;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- src/mbr_checker.sv -----
// Port-level checker for the bus router, bound to the top level.
module mbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] read_data_o,
  input logic        uart_valid_o,
  input logic [7:0]  uart_byte_o,
  input logic        fault_o,
  input logic [63:0] compare_value_o
);

  // A held result keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) &&
    $stable(compare_value_o))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item accepted while another is in flight");

  // A UART byte comes from a write, which neither reads nor faults.
  a_uart_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && uart_valid_o |-> read_data_o == 32'd0 && !fault_o)
    else $error("UART item carries read data or a fault");

  // A faulting access returns no data, and a silent UART carries no byte.
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (fault_o || !uart_valid_o) |->
    (!fault_o || read_data_o == 32'd0) && (uart_valid_o || uart_byte_o == 8'd0))
    else $error("fault with data or stray UART byte");

endmodule

bind mmio_bus_router_with_timer_compare mbr_checker u_mbr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .read_data_o     (read_data_o),
  .uart_valid_o    (uart_valid_o),
  .uart_byte_o     (uart_byte_o),
  .fault_o         (fault_o),
  .compare_value_o (compare_value_o)
);
